/* src/gec_pkg.sv */
// Shared constants, types and tables for the gamma encoder.
package gec_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LOG_FRAC      = 24;
    localparam int TERMS         = 12;
    localparam int LOG_LAT       = 2 + LOG_FRAC;
    localparam int EXP_LAT       = 3 + 3 * TERMS;
    localparam int CH_LAT        = LOG_LAT + EXP_LAT;

    localparam logic [31:0] Q31_ONE       = 32'h8000_0000;
    localparam logic [30:0] LN2_Q31       = 31'h58B9_0BFC;
    localparam logic [15:0] INV_GAMMA_RST = 16'd1862;
    localparam logic        REG_INV_GAMMA = 1'b0;

    typedef logic [1:0] flag_t;
    localparam flag_t FLG_NONE = 2'd0;
    localparam flag_t FLG_ZERO = 2'd1;
    localparam flag_t FLG_FULL = 2'd2;

    typedef logic [32:0] recip_t;

    function automatic recip_t recip(input logic [3:0] k);
        recip_t r;
        begin
            case (k)
                4'd1:    r = 33'd4294967296;
                4'd2:    r = 33'd2147483648;
                4'd3:    r = 33'd1431655765;
                4'd4:    r = 33'd1073741824;
                4'd5:    r = 33'd858993459;
                4'd6:    r = 33'd715827882;
                4'd7:    r = 33'd613566756;
                4'd8:    r = 33'd536870912;
                4'd9:    r = 33'd477218588;
                4'd10:   r = 33'd429496729;
                4'd11:   r = 33'd390451572;
                4'd12:   r = 33'd357913941;
                default: r = 33'd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* src/gec_log.sv */
// Pipelined negative base-two logarithm: normalisation and one squaring per stage.
module gec_log #(
    parameter int FRAC_BITS = gec_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [23:0]            x_in,
    output logic [23:0]            frac,
    output logic [4:0]             msb,
    output gec_pkg::flag_t         flag
);

    localparam int N = gec_pkg::LOG_FRAC;

    logic [23:0]    x_reg;
    logic [4:0]     p_reg [0:N+1];
    gec_pkg::flag_t fl_reg [0:N+1];
    logic [31:0]    m_reg [0:N];
    logic [23:0]    fr_reg [0:N];

    logic [4:0]     p_next;
    gec_pkg::flag_t fl_next;

    always_comb
    begin
        p_next = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (x_in[i])
            begin
                p_next = 5'(i);
            end
        end
        if (x_in == 24'd0 || x_in[23])
        begin
            fl_next = gec_pkg::FLG_ZERO;
        end
        else if ({1'b0, x_in} >= (25'd1 << FRAC_BITS))
        begin
            fl_next = gec_pkg::FLG_FULL;
        end
        else
        begin
            fl_next = gec_pkg::FLG_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_in;
            p_reg[0]  <= p_next;
            fl_reg[0] <= fl_next;
            m_reg[0]  <= {8'd0, x_reg} << (5'd31 - p_reg[0]);
            fr_reg[0] <= 24'd0;
            p_reg[1]  <= p_reg[0];
            fl_reg[1] <= fl_reg[0];
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_sq
        logic [63:0] sq_next;
        logic [32:0] s_next;

        assign sq_next = m_reg[i] * m_reg[i];
        assign s_next  = sq_next[63:31];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i+1]  <= s_next[32] ? s_next[32:1] : s_next[31:0];
                fr_reg[i+1] <= {fr_reg[i][22:0], s_next[32]};
                p_reg[i+2]  <= p_reg[i+1];
                fl_reg[i+2] <= fl_reg[i+1];
            end
        end
    end

    assign frac = fr_reg[N];
    assign msb  = p_reg[N+1];
    assign flag = fl_reg[N+1];

endmodule

/* src/gec_exp.sv */
// Pipelined scaling by the exponent, power-of-two series and byte rounding.
module gec_exp #(
    parameter int FRAC_BITS = gec_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           en,
    input  logic [15:0]    inv_gamma,
    input  logic [23:0]    frac,
    input  logic [4:0]     msb,
    input  gec_pkg::flag_t flag,
    output logic [7:0]     code
);

    localparam int T = gec_pkg::TERMS;

    logic [32:0]    t_reg;
    gec_pkg::flag_t fl0_reg;
    logic [30:0]    z_reg [0:3*T];
    logic [4:0]     ti_reg [0:3*T];
    gec_pkg::flag_t fl_reg [0:3*T];
    logic [31:0]    r_reg [0:3*T];
    logic [30:0]    a_reg [0:T-1];
    logic [30:0]    b_reg [0:T-1];
    logic [31:0]    q_reg [0:T-1];
    logic [7:0]     code_reg;

    logic [4:0]     ip_next;
    logic [28:0]    nl_next;
    logic [44:0]    t_next;
    logic [8:0]     ti_next;
    logic [54:0]    z_next;

    always_comb
    begin
        ip_next = 5'(FRAC_BITS) - msb;
        nl_next = {ip_next, 24'd0} - {5'd0, frac};
        t_next  = inv_gamma * nl_next;
        ti_next = t_reg[32:24];
        z_next  = t_reg[23:0] * gec_pkg::LN2_Q31;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next[44:12];
            fl0_reg   <= flag;
            z_reg[0]  <= z_next[54:24];
            ti_reg[0] <= ti_next[4:0];
            fl_reg[0] <= (fl0_reg == gec_pkg::FLG_NONE && ti_next >= 9'd31)
                         ? gec_pkg::FLG_ZERO : fl0_reg;
            r_reg[0]  <= gec_pkg::Q31_ONE;
        end
    end

    for (genvar j = 0; j < T; j++)
    begin : g_term
        localparam logic [3:0] K = 4'(T - j);
        logic [61:0] prod_next;
        logic [63:0] qe_next;
        logic [35:0] qk_next;
        logic [31:0] rem_next;
        logic [31:0] q_next;

        always_comb
        begin
            prod_next = z_reg[3*j] * r_reg[3*j];
            qe_next   = a_reg[j] * gec_pkg::recip(K);
            qk_next   = q_reg[j] * K;
            rem_next  = {1'b0, b_reg[j]} - qk_next[31:0];
            q_next    = (rem_next >= 32'(K)) ? q_reg[j] + 32'd1 : q_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[j]        <= prod_next[61:31];
                z_reg[3*j+1]    <= z_reg[3*j];
                ti_reg[3*j+1]   <= ti_reg[3*j];
                fl_reg[3*j+1]   <= fl_reg[3*j];
                r_reg[3*j+1]    <= r_reg[3*j];
                q_reg[j]        <= qe_next[63:32];
                b_reg[j]        <= a_reg[j];
                z_reg[3*j+2]    <= z_reg[3*j+1];
                ti_reg[3*j+2]   <= ti_reg[3*j+1];
                fl_reg[3*j+2]   <= fl_reg[3*j+1];
                r_reg[3*j+2]    <= r_reg[3*j+1];
                r_reg[3*j+3]    <= gec_pkg::Q31_ONE - q_next;
                z_reg[3*j+3]    <= z_reg[3*j+2];
                ti_reg[3*j+3]   <= ti_reg[3*j+2];
                fl_reg[3*j+3]   <= fl_reg[3*j+2];
            end
        end
    end

    logic [31:0] v_next;
    logic [39:0] c_next;

    always_comb
    begin
        v_next = r_reg[3*T] >> ti_reg[3*T];
        c_next = ({v_next, 8'd0} - {8'd0, v_next}) + 40'h00_4000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (fl_reg[3*T])
                gec_pkg::FLG_ZERO: code_reg <= 8'd0;
                gec_pkg::FLG_FULL: code_reg <= 8'd255;
                default:           code_reg <= c_next[38:31];
            endcase
        end
    end

    assign code = code_reg;

endmodule

/* src/gec_channel.sv */
// One colour channel: logarithm pipeline followed by exponent pipeline.
module gec_channel #(
    parameter int FRAC_BITS = gec_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] inv_gamma,
    input  logic [23:0] x_in,
    output logic [7:0]  code
);

    logic [23:0]    frac;
    logic [4:0]     msb;
    gec_pkg::flag_t flag;

    gec_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .clk  (clk),
        .en   (en),
        .x_in (x_in),
        .frac (frac),
        .msb  (msb),
        .flag (flag)
    );

    gec_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
        .clk       (clk),
        .en        (en),
        .inv_gamma (inv_gamma),
        .frac      (frac),
        .msb       (msb),
        .flag      (flag),
        .code      (code)
    );

endmodule

/* src/gamma_encode_rgb_to_8bit.sv */
// Top level of the gamma encoder: stream ports, register port and channel pipelines.
// From an accepted request to its result the pipeline has 26 logarithm stages
// (input, normalisation and 24 squarings) and 39 exponent stages (scaling, ln2
// conversion, three per series term and rounding).
// Throughput is one pixel per cycle; the whole pipeline holds while a result waits.
// Reset clears the valid line and sets inv_gamma to 1862; data registers are not reset.
module gamma_encode_rgb_to_8bit #(
    parameter int FRAC_BITS = gec_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // red_in, green_in, blue_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blue_out, green_out, red_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LAT = gec_pkg::CH_LAT;

    logic [15:0]    inv_gamma_reg;
    logic [LAT-1:0] vld_reg;
    logic           en;
    logic [7:0]     red_code;
    logic [7:0]     green_code;
    logic [7:0]     blue_code;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == gec_pkg::REG_INV_GAMMA) ? {16'd0, inv_gamma_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_gamma_reg <= gec_pkg::INV_GAMMA_RST;
        end
        else if (psel && penable && pwrite && paddr[2] == gec_pkg::REG_INV_GAMMA)
        begin
            inv_gamma_reg <= pwdata[15:0];
        end
    end

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {red_code, green_code, blue_code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    gec_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
        .clk (clk), .en (en), .inv_gamma (inv_gamma_reg),
        .x_in (s_tdata[23:0]), .code (red_code)
    );

    gec_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
        .clk (clk), .en (en), .inv_gamma (inv_gamma_reg),
        .x_in (s_tdata[47:24]), .code (green_code)
    );

    gec_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .clk (clk), .en (en), .inv_gamma (inv_gamma_reg),
        .x_in (s_tdata[71:48]), .code (blue_code)
    );

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output is empty");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid line moved during a stall");

endmodule

/* dv/gamma_encode_rgb_to_8bit_test.sv */
// Testbench for the gamma encoder: random pixel stream checked against a fixed-point predictor.
module gamma_encode_rgb_to_8bit_test;

    localparam int PIPE_LAT  = 65;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_code_t;

    class pixel_board;
        pixel_code_t pending[$];
        logic [15:0] inv_gamma;
        int          errors;

        function new();
            inv_gamma = gec_pkg::INV_GAMMA_RST;
            errors    = 0;
        endfunction

        function logic [7:0] encode(logic [23:0] x);
            logic [63:0] m;
            logic [63:0] frac;
            logic [63:0] nl;
            logic [63:0] t;
            logic [63:0] ti;
            logic [63:0] tf;
            logic [63:0] z;
            logic [63:0] r;
            logic [63:0] v;
            int          p;
            if (x == 0 || x[23])
                return 8'd0;
            if (x >= (24'd1 << gec_pkg::FRAC_BITS_DEF))
                return 8'd255;
            p = 0;
            for (int i = 0; i < 24; i++)
                if (x[i])
                    p = i;
            m = 64'(x) << (31 - p);
            frac = 0;
            for (int i = 0; i < gec_pkg::LOG_FRAC; i++)
            begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000)
                begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            nl = (64'(gec_pkg::FRAC_BITS_DEF - p) << gec_pkg::LOG_FRAC) - frac;
            t  = (64'(inv_gamma) * nl) >> 12;
            ti = t >> gec_pkg::LOG_FRAC;
            tf = t & ((64'd1 << gec_pkg::LOG_FRAC) - 1);
            if (ti >= 31)
                return 8'd0;
            z = (tf * 64'(gec_pkg::LN2_Q31)) >> gec_pkg::LOG_FRAC;
            r = 64'(gec_pkg::Q31_ONE);
            for (int k = gec_pkg::TERMS; k >= 1; k--)
                r = 64'(gec_pkg::Q31_ONE) - ((z * r) >> 31) / k;
            v = r >> ti;
            if (v > 64'(gec_pkg::Q31_ONE))
                v = 64'(gec_pkg::Q31_ONE);
            return 8'((v * 255 + (64'd1 << 30)) >> 31);
        endfunction

        function void note_pixel(logic [71:0] d);
            pixel_code_t c;
            c.red   = encode(d[23:0]);
            c.green = encode(d[47:24]);
            c.blue  = encode(d[71:48]);
            pending.push_back(c);
        endfunction

        function void check_pixel(logic [23:0] d);
            pixel_code_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[7:0] != e.blue)
            begin
                $error("blue_out expected %0d actual %0d", e.blue, d[7:0]);
                errors++;
            end
            if (d[15:8] != e.green)
            begin
                $error("green_out expected %0d actual %0d", e.green, d[15:8]);
                errors++;
            end
            if (d[23:16] != e.red)
            begin
                $error("red_out expected %0d actual %0d", e.red, d[23:16]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // red_in, green_in, blue_in
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // blue_out, green_out, red_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pixel_board board;
    int         cycle;
    int         hold_off;
    int         rx_wait;
    int         rx_draw;
    bit         rx_stall_en;

    gamma_encode_rgb_to_8bit u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_pixel(m_tdata);

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end
        else if (rx_stall_en && rst_n && m_tvalid && m_tready)
        begin
            rx_draw   = $urandom_range(0, 3);
            rx_wait  <= rx_draw;
            m_tready <= (rx_draw == 0);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.inv_gamma = val[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(input logic [71:0] d);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_pixel(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 255));
            default: return 24'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic random_pixels(input int n);
        for (int i = 0; i < n; i++)
            send_pixel({rand_chan(), rand_chan(), rand_chan()});
    endtask

    initial
    begin
        logic [23:0] edge_vals [12] = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000,
            24'hFFFFFF, 24'h010000, 24'h00FFFF, 24'h008000, 24'h000002, 24'h000100,
            24'h00C000, 24'h555555};
        board       = new();
        cycle       = 0;
        hold_off    = 0;
        rx_wait     = 0;
        rx_draw     = 0;
        rx_stall_en = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 12; i++)
            send_pixel({edge_vals[i], edge_vals[(i + 3) % 12], edge_vals[(i + 7) % 12]});
        random_pixels(200);
        drain();
        write_reg({gec_pkg::REG_INV_GAMMA, 2'b00}, 32'd1);
        for (int i = 0; i < 12; i++)
            send_pixel({edge_vals[i], edge_vals[(i + 5) % 12], edge_vals[(i + 2) % 12]});
        rx_stall_en = 1'b1;
        random_pixels(250);
        drain();
        write_reg({gec_pkg::REG_INV_GAMMA, 2'b00}, 32'd65535);
        random_pixels(250);
        hold_off <= 200;
        random_pixels(200);
        drain();
        write_reg({gec_pkg::REG_INV_GAMMA, 2'b00}, 32'd4096);
        random_pixels(300);
        drain();
        write_reg({gec_pkg::REG_INV_GAMMA, 2'b00}, 32'h0000_AAAA);
        random_pixels(300);
        drain();
        write_reg({gec_pkg::REG_INV_GAMMA, 2'b00}, 32'd1862);
        rx_stall_en = 1'b0;
        random_pixels(400);
        drain();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* gamma_encode_rgb_to_8bit.f */
src/gec_pkg.sv
src/gec_log.sv
src/gec_exp.sv
src/gec_channel.sv
src/gamma_encode_rgb_to_8bit.sv
dv/gamma_encode_rgb_to_8bit_test.sv
